// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by session_reconnect_backoff_fsm_unit
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/srb_pkg.sv =====
// ----------------------------------------------------------------------------
// srb_pkg
// Types, codes and the backoff delay table of the session reconnect block.
// ----------------------------------------------------------------------------
package srb_pkg;

    localparam int DELAY_STEPS = 6;
    localparam logic [2:0] LAST_STEP = 3'(DELAY_STEPS - 1);

    localparam logic [2:0] CAUSE_NONE         = 3'd0;
    localparam logic [2:0] CAUSE_ENTITY_ERROR = 3'd4;

    localparam logic [10:0] DELAY_TABLE [8] = '{
        11'd100, 11'd200, 11'd400, 11'd800, 11'd1600, 11'd2000, 11'd2000, 11'd2000
    };

    typedef enum logic [2:0] {
        ST_SAFE_BOOT  = 3'd0,
        ST_WAIT_AGENT = 3'd1,
        ST_CREATE     = 3'd2,
        ST_ACTIVE     = 3'd3,
        ST_TEARDOWN   = 3'd4,
        ST_BACKOFF    = 3'd5
    } session_state_t;

    typedef enum logic [2:0] {
        CMD_LEAVE_BOOT   = 3'd0,
        CMD_PING         = 3'd1,
        CMD_CREATED      = 3'd2,
        CMD_BEGIN_TEAR   = 3'd3,
        CMD_TEAR_DONE    = 3'd4,
        CMD_TICK         = 3'd5
    } command_t;

    typedef struct packed {
        logic           expired;
        logic [10:0]    delay;
        logic [31:0]    reconnects;
        logic [31:0]    generation;
        logic [2:0]     cause;
        session_state_t state;
    } srb_result_t;

endpackage

// ===== src/session_reconnect_backoff_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// session_reconnect_backoff_fsm_unit
// Session lifecycle controller with capped exponential reconnect backoff.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ group is one event: s_tuser carries the command,
//   s_tdata the success flag, current millisecond time and teardown cause.
//   Every request yields exactly one result on the m_ group showing the
//   session state, stored cause, generation, reconnect count, backoff delay
//   and the backoff-expired flag as they stand after the event.
//   Each result is registered and shown in the cycle after its request is
//   accepted; one request is taken every cycle while s_tready is high.
//   The result register frees on the cycle it is taken, so s_tready only
//   drops while a result waits and m_tready is low; the state is not
//   advanced for a request until it is accepted.
//   Reset puts the session in safe boot with all counters, cause, delay and
//   deadline at zero, and empties the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module session_reconnect_backoff_fsm_unit
    import srb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] success, [32:1] now_time, [35:33] teardown_cause, [39:36] zero
    input  logic [39:0] s_tdata,
    // [2:0] command
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [2:0] session_state, [5:3] cause_now, [37:6] generation,
    // [69:38] reconnect_count, [80:70] backoff_delay, [81] backoff_expired,
    // [87:82] zero
    output logic [87:0] m_tdata
);

    srb_result_t result;
    srb_result_t out_reg;
    logic        valid_reg;
    logic        accept;

    assign s_tready = !valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    srb_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (accept),
        .command        (s_tuser),
        .success        (s_tdata[0]),
        .now_time       (s_tdata[32:1]),
        .teardown_cause (s_tdata[35:33]),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= result;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, out_reg.expired, out_reg.delay, out_reg.reconnects,
                       out_reg.generation, out_reg.cause, out_reg.state};

    `ASSERT_NXT(a_result_follows, accept, m_tvalid, "accepted request gave no result")
    `ASSERT_IMP(a_expired_wait, m_tvalid && out_reg.expired, out_reg.state == ST_WAIT_AGENT, "expiry without return to wait agent")
    `ASSERT_IMP(a_active_gen, m_tvalid && out_reg.state == ST_ACTIVE, out_reg.generation != 32'd0, "active session with zero generation")
    `ASSERT_IMP(a_backoff_delay, m_tvalid && out_reg.state == ST_BACKOFF, out_reg.delay != 11'd0, "backoff with zero delay")

endmodule

// ===== src/srb_ctrl.sv =====
// ----------------------------------------------------------------------------
// srb_ctrl
// Lifecycle state machine and session counters; one event per enabled cycle.
// ----------------------------------------------------------------------------
module srb_ctrl
    import srb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step_en,
    input  logic [2:0]  command,
    input  logic        success,
    input  logic [31:0] now_time,
    input  logic [2:0]  teardown_cause,
    output srb_result_t result
);

    session_state_t state_reg, state_next;
    logic [2:0]     cause_reg, cause_next;
    logic [31:0]    gen_reg, gen_next;
    logic [31:0]    recon_reg, recon_next;
    logic [2:0]     index_reg, index_next;
    logic [10:0]    delay_reg, delay_next;
    logic [31:0]    deadline_reg, deadline_next;
    logic           expired;

    command_t    cmd;
    logic        deadline_hit;
    logic [31:0] since_deadline;
    logic [31:0] gen_inc;
    logic [10:0] table_delay;

    assign cmd            = command_t'(command);
    assign since_deadline = now_time - deadline_reg;
    assign deadline_hit   = ~since_deadline[31];
    assign gen_inc        = gen_reg + 32'd1;
    assign table_delay    = DELAY_TABLE[index_reg];

    // Next lifecycle state
    always_comb
    begin
        state_next = state_reg;
        unique case (cmd)
            CMD_LEAVE_BOOT:
                if (state_reg == ST_SAFE_BOOT) state_next = ST_WAIT_AGENT;
            CMD_PING:
                if (state_reg == ST_WAIT_AGENT)
                    state_next = success ? ST_CREATE : ST_BACKOFF;
            CMD_CREATED:
                if (state_reg == ST_CREATE)
                    state_next = success ? ST_ACTIVE : ST_TEARDOWN;
            CMD_BEGIN_TEAR:
                if (state_reg != ST_TEARDOWN) state_next = ST_TEARDOWN;
            CMD_TEAR_DONE:
                if (state_reg == ST_TEARDOWN) state_next = ST_BACKOFF;
            CMD_TICK:
                if (state_reg == ST_BACKOFF && deadline_hit) state_next = ST_WAIT_AGENT;
            default:
                state_next = state_reg;
        endcase
    end

    // Counters, backoff and the expiry flag
    always_comb
    begin
        logic enter_backoff;
        enter_backoff = 1'b0;
        cause_next    = cause_reg;
        gen_next      = gen_reg;
        recon_next    = recon_reg;
        index_next    = index_reg;
        delay_next    = delay_reg;
        deadline_next = deadline_reg;
        expired       = 1'b0;
        unique case (cmd)
            CMD_LEAVE_BOOT:
                if (state_reg == ST_SAFE_BOOT) cause_next = CAUSE_NONE;
            CMD_PING:
                if (state_reg == ST_WAIT_AGENT && !success) enter_backoff = 1'b1;
            CMD_CREATED:
                if (state_reg == ST_CREATE)
                begin
                    if (!success)
                        cause_next = CAUSE_ENTITY_ERROR;
                    else
                    begin
                        if (gen_reg == 32'd0)
                            gen_next = 32'd1;
                        else
                        begin
                            // skip zero on wrap
                            gen_next = (gen_inc == 32'd0) ? 32'd1 : gen_inc;
                            if (recon_reg != 32'hFFFF_FFFF) recon_next = recon_reg + 32'd1;
                        end
                        index_next = 3'd0;
                        delay_next = 11'd0;
                    end
                end
            CMD_BEGIN_TEAR:
                if (state_reg != ST_TEARDOWN) cause_next = teardown_cause;
            CMD_TEAR_DONE:
                if (state_reg == ST_TEARDOWN) enter_backoff = 1'b1;
            CMD_TICK:
                expired = (state_reg == ST_BACKOFF) && deadline_hit;
            default:
                expired = 1'b0;
        endcase
        if (enter_backoff)
        begin
            delay_next    = table_delay;
            deadline_next = now_time + 32'(table_delay);
            if (index_reg < LAST_STEP) index_next = index_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_SAFE_BOOT;
            cause_reg    <= CAUSE_NONE;
            gen_reg      <= '0;
            recon_reg    <= '0;
            index_reg    <= '0;
            delay_reg    <= '0;
            deadline_reg <= '0;
        end
        else if (step_en)
        begin
            state_reg    <= state_next;
            cause_reg    <= cause_next;
            gen_reg      <= gen_next;
            recon_reg    <= recon_next;
            index_reg    <= index_next;
            delay_reg    <= delay_next;
            deadline_reg <= deadline_next;
        end
    end

    always_comb
    begin
        result.state      = state_next;
        result.cause      = cause_next;
        result.generation = gen_next;
        result.reconnects = recon_next;
        result.delay      = delay_next;
        result.expired    = expired;
    end

endmodule
